>>> rtl/core/frac_acc_pkg.sv
// frac_acc_pkg: widths, item types, command codes and sign helpers for the
// fraction accumulator. Depends on nothing; used by frac_acc_gcd and the top level.

package frac_acc_pkg;

	// internal value width and the fixed width of the item fields
	localparam int VALUE_WIDTH = 32;
	localparam int FIELD_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	typedef logic [VALUE_WIDTH-1:0]        value_t;
	typedef logic signed [FIELD_WIDTH-1:0] field_t;

	// command codes
	localparam logic [2:0] CMD_LOAD   = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_SUB    = 3'd2;
	localparam logic [2:0] CMD_MUL    = 3'd3;
	localparam logic [2:0] CMD_DIV    = 3'd4;
	localparam logic [2:0] CMD_REDUCE = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		field_t     operand_numerator;
		field_t     operand_denominator;
	} cmd_item_t;

	typedef struct packed {
		field_t result_numerator;
		field_t result_denominator;
		logic   zero_denominator;
	} res_item_t;

	// sign-extend or truncate a field to the internal width
	function automatic value_t to_value(input field_t f);
		return VALUE_WIDTH'(signed'(f));
	endfunction

	// sign-extend or truncate an internal value to the field width
	function automatic field_t to_field(input value_t v);
		return FIELD_WIDTH'(signed'(v));
	endfunction

	// absolute value; the most negative value maps to 2^(VALUE_WIDTH-1)
	function automatic value_t magnitude(input value_t v);
		return v[VALUE_WIDTH-1] ? value_t'(-v) : v;
	endfunction

endpackage

>>> rtl/core/frac_acc_gcd.sv
// frac_acc_gcd: divides two nonzero magnitudes by their greatest common divisor.
// Binary gcd followed by two restoring divisions on one shared subtractor.
// Depends on frac_acc_pkg.

module frac_acc_gcd import frac_acc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  value_t num_mag,
	input  value_t den_mag,
	output logic   done,
	output value_t num_quo,
	output value_t den_quo
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STRIP = 3'd1;
	localparam logic [2:0] S_GCD   = 3'd2;
	localparam logic [2:0] S_DIVN  = 3'd3;
	localparam logic [2:0] S_DIVD  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	value_t           x_q;
	value_t           y_q;
	value_t           mn_q;
	value_t           md_q;

	logic             div_bit;
	value_t           rem_shift;
	value_t           sub_a;
	value_t           sub_b;
	logic [VALUE_WIDTH:0] diff;
	logic             borrow;
	value_t           dv;
	value_t           dv_neg;

	// shared subtractor: x - y during gcd, shifted remainder - divisor during division
	always_comb begin
		div_bit   = (state_q == S_DIVN) ? mn_q[VALUE_WIDTH-1] : md_q[VALUE_WIDTH-1];
		rem_shift = {y_q[VALUE_WIDTH-2:0], div_bit};
		sub_a     = (state_q == S_GCD) ? x_q : rem_shift;
		sub_b     = (state_q == S_GCD) ? y_q : x_q;
		diff      = {1'b0, sub_a} - {1'b0, sub_b};
		borrow    = diff[VALUE_WIDTH];
		dv        = diff[VALUE_WIDTH-1:0];
		dv_neg    = value_t'(-dv);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_STRIP;
				end
				S_STRIP: begin
					if (x_q[0] || y_q[0]) state_q <= S_GCD;
				end
				S_GCD: begin
					if (x_q == y_q) begin
						cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
						state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
						state_q <= S_DIVD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DIVD: begin
					if (cnt_q == '0) state_q <= S_DONE;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: gcd working pair, dividends that turn into quotients, remainder in y
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					x_q  <= num_mag;
					y_q  <= den_mag;
					mn_q <= num_mag;
					md_q <= den_mag;
				end
			end
			S_STRIP: begin
				// common factors of two leave the dividends as well
				if (!x_q[0] && !y_q[0]) begin
					x_q  <= x_q >> 1;
					y_q  <= y_q >> 1;
					mn_q <= mn_q >> 1;
					md_q <= md_q >> 1;
				end
			end
			S_GCD: begin
				if (x_q == y_q) y_q <= '0;
				else if (!x_q[0]) x_q <= x_q >> 1;
				else if (!y_q[0]) y_q <= y_q >> 1;
				else if (!borrow) x_q <= dv >> 1;
				else y_q <= dv_neg >> 1;
			end
			S_DIVN: begin
				mn_q <= {mn_q[VALUE_WIDTH-2:0], ~borrow};
				if (cnt_q == '0) y_q <= '0;
				else y_q <= borrow ? rem_shift : dv;
			end
			S_DIVD: begin
				md_q <= {md_q[VALUE_WIDTH-2:0], ~borrow};
				y_q  <= borrow ? rem_shift : dv;
			end
			default: begin
			end
		endcase
	end

	assign done    = (state_q == S_DONE);
	assign num_quo = mn_q;
	assign den_quo = md_q;

endmodule

>>> rtl/core/fraction_accumulator.sv
// fraction_accumulator: top level, command sequencer, shared multiplier and output register.
// Depends on frac_acc_pkg and frac_acc_gcd.

// Keeps a running signed fraction and takes one command item at a time; cmd_stall is high
// while an item is being worked. Load and the unused codes leave cmd_stall low, multiply and
// divide run states M0 to M2, add and subtract M0 to M3: the products go one after another
// through a single VALUE_WIDTH by VALUE_WIDTH multiplier. Reduce goes straight to its output
// step when the numerator or the denominator is zero; otherwise it runs a binary gcd and then
// two bit-serial divisions on one shared subtractor. Only reduce emits an item; the result
// sits in an output register, so new commands are taken while it waits, and a later reduce
// holds in its last step until the register is free. Signs of numerator and denominator are
// kept as they are.

module fraction_accumulator import frac_acc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_M0   = 3'd1;
	localparam logic [2:0] S_M1   = 3'd2;
	localparam logic [2:0] S_M2   = 3'd3;
	localparam logic [2:0] S_M3   = 3'd4;
	localparam logic [2:0] S_RED  = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0] state_q;
	value_t     an_q;
	value_t     ad_q;
	logic       out_valid_q;
	res_item_t  out_q;
	logic [2:0] cmd_q;
	value_t     on_q;
	value_t     od_q;
	value_t     p_q;
	value_t     t_q;

	logic       accept;
	logic       emit;
	logic       is_addsub;
	value_t     mul_a;
	value_t     mul_b;
	value_t     prod;
	logic       gcd_start;
	logic       gcd_done;
	value_t     num_quo;
	value_t     den_quo;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || !res_stall);
	assign is_addsub = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);
	assign gcd_start = (state_q == S_RED) && (ad_q != '0) && (an_q != '0);

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			S_M0: begin
				mul_a = an_q;
				mul_b = (cmd_q == CMD_MUL) ? on_q : od_q;
			end
			S_M1: begin
				if (is_addsub) begin
					mul_a = on_q;
					mul_b = ad_q;
				end else begin
					mul_a = ad_q;
					mul_b = (cmd_q == CMD_DIV) ? on_q : od_q;
				end
			end
			default: begin
				mul_a = ad_q;
				mul_b = od_q;
			end
		endcase
	end

	// low half of the product wraps at the value width
	assign prod = mul_a * mul_b;

	frac_acc_gcd u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gcd_start),
		.num_mag (magnitude(an_q)),
		.den_mag (magnitude(ad_q)),
		.done    (gcd_done),
		.num_quo (num_quo),
		.den_quo (den_quo)
	);

	// sequencer, accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			an_q        <= '0;
			ad_q        <= value_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (!res_stall) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd_item.command)
							CMD_LOAD: begin
								an_q <= to_value(cmd_item.operand_numerator);
								ad_q <= to_value(cmd_item.operand_denominator);
							end
							CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
								state_q <= S_M0;
							end
							CMD_REDUCE: begin
								state_q <= S_RED;
							end
							default: begin
							end
						endcase
					end
				end
				S_M0: begin
					state_q <= S_M1;
				end
				S_M1: begin
					state_q <= S_M2;
				end
				S_M2: begin
					if (is_addsub) begin
						an_q    <= (cmd_q == CMD_ADD) ? value_t'(t_q + p_q) : value_t'(t_q - p_q);
						state_q <= S_M3;
					end else begin
						an_q    <= t_q;
						ad_q    <= p_q;
						state_q <= S_IDLE;
					end
				end
				S_M3: begin
					ad_q    <= p_q;
					state_q <= S_IDLE;
				end
				S_RED: begin
					// zero denominator: emit as is; zero numerator: becomes 0/1
					if (ad_q == '0) begin
						state_q <= S_EMIT;
					end else if (an_q == '0) begin
						ad_q    <= value_t'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (gcd_done) begin
						an_q    <= an_q[VALUE_WIDTH-1] ? value_t'(-num_quo) : num_quo;
						ad_q    <= ad_q[VALUE_WIDTH-1] ? value_t'(-den_quo) : den_quo;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand capture, product register and output item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_item.command;
			on_q  <= to_value(cmd_item.operand_numerator);
			od_q  <= to_value(cmd_item.operand_denominator);
		end
		if (state_q == S_M0 || state_q == S_M1 || state_q == S_M2) p_q <= prod;
		if (state_q == S_M1) t_q <= p_q;
		if (emit) begin
			out_q.result_numerator   <= to_field(an_q);
			out_q.result_denominator <= to_field(ad_q);
			out_q.zero_denominator   <= (ad_q == '0);
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

endmodule
